// ===== hw/rtl/gsha_pkg.sv =====
`timescale 1ns / 1ps
// gsha_pkg: sizes, codes, types and the cell address helper shared by the
// greedy assignment block. No dependencies.
package gsha_pkg;

	localparam int MAX_ROWS   = 16;
	localparam int MAX_COLS   = 16;
	localparam int RESULT_CAP = 16;

	localparam int SCORE_W = 16;
	localparam int FIELD_W = 4;   // width of row/col fields on the ports
	localparam int CFG_W   = 5;
	localparam int CFG_IDX_W = 2;

	localparam int ROW_W  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
	localparam int COL_W  = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
	localparam int RN_W   = $clog2(MAX_ROWS + 1);
	localparam int CN_W   = $clog2(MAX_COLS + 1);
	localparam int RND_W  = $clog2(RESULT_CAP + 1);
	localparam int DEPTH  = MAX_ROWS * MAX_COLS;
	localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_MATCH_COUNT = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_ROWS_USED   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_COLS_USED   = 2'd2;

	// request kinds
	localparam logic KIND_LOAD = 1'b0;
	localparam logic KIND_RUN  = 1'b1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ROUND,
		ST_SCAN,
		ST_DRAIN,
		ST_DECIDE,
		ST_FINISH
	} scan_state_t;

	typedef struct packed {
		logic [CFG_W-1:0] match_count;
		logic [CFG_W-1:0] rows_used;
		logic [CFG_W-1:0] cols_used;
	} cfg_t;

	typedef struct packed {
		logic             valid;
		logic             found;
		logic [ROW_W-1:0] row;
		logic [COL_W-1:0] col;
		logic             last;
	} emit_t;

	typedef struct packed {
		logic busy;
		logic pend_valid;
	} status_t;

	function automatic logic [ADDR_W-1:0] cell_addr(input logic [ROW_W-1:0] r,
		input logic [COL_W-1:0] c);
		cell_addr = ADDR_W'(r) * ADDR_W'(MAX_COLS) + ADDR_W'(c);
	endfunction

endpackage

// ===== hw/rtl/gsha_ram.sv =====
`timescale 1ns / 1ps
// gsha_ram: generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
module gsha_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 256,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ===== hw/rtl/gsha_scan.sv =====
`timescale 1ns / 1ps
// gsha_scan: round sequencer, score scan over the RAM, used-row/col masks and
// the held match that decides the last flag. Depends on gsha_pkg.
module gsha_scan (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  gsha_pkg::cfg_t                cfg,
	input  logic                          slot_free,
	output logic                          rd_en,
	output logic [gsha_pkg::ADDR_W-1:0]   rd_addr,
	input  logic [gsha_pkg::SCORE_W-1:0]  rd_data,
	output gsha_pkg::emit_t               emit,
	output gsha_pkg::status_t             status
);

	gsha_pkg::scan_state_t state_q, state_d;

	logic [gsha_pkg::RND_W-1:0] rounds_q;
	logic [gsha_pkg::RN_W-1:0]  nr_q;
	logic [gsha_pkg::CN_W-1:0]  nc_q;
	logic [gsha_pkg::ROW_W-1:0] i_q;
	logic [gsha_pkg::COL_W-1:0] j_q;

	logic                       valid_s1;
	logic                       elig_s1;
	logic [gsha_pkg::ROW_W-1:0] row_s1;
	logic [gsha_pkg::COL_W-1:0] col_s1;

	logic                              have_q;
	logic signed [gsha_pkg::SCORE_W-1:0] best_q;
	logic [gsha_pkg::ROW_W-1:0]        best_row_q;
	logic [gsha_pkg::COL_W-1:0]        best_col_q;

	logic [gsha_pkg::MAX_ROWS-1:0] row_taken_q;
	logic [gsha_pkg::MAX_COLS-1:0] col_taken_q;

	logic                       pend_valid_q;
	logic [gsha_pkg::ROW_W-1:0] pend_row_q;
	logic [gsha_pkg::COL_W-1:0] pend_col_q;

	logic issue, round_init, commit, row_end, last_cell, better;

	assign row_end   = (gsha_pkg::CN_W'(j_q) + gsha_pkg::CN_W'(1)) == nc_q;
	assign last_cell = row_end && ((gsha_pkg::RN_W'(i_q) + gsha_pkg::RN_W'(1)) == nr_q);
	assign better    = !have_q || ($signed(rd_data) > best_q);

	always_comb begin
		state_d    = state_q;
		emit       = '0;
		issue      = 1'b0;
		round_init = 1'b0;
		commit     = 1'b0;
		case (state_q)
			gsha_pkg::ST_IDLE: begin
				if (start) begin
					state_d = gsha_pkg::ST_ROUND;
				end
			end
			gsha_pkg::ST_ROUND: begin
				if (rounds_q == '0 || nr_q == '0 || nc_q == '0) begin
					state_d = gsha_pkg::ST_FINISH;
				end else begin
					round_init = 1'b1;
					state_d    = gsha_pkg::ST_SCAN;
				end
			end
			gsha_pkg::ST_SCAN: begin
				issue = 1'b1;
				if (last_cell) begin
					state_d = gsha_pkg::ST_DRAIN;
				end
			end
			gsha_pkg::ST_DRAIN: begin
				state_d = gsha_pkg::ST_DECIDE;
			end
			gsha_pkg::ST_DECIDE: begin
				if (have_q && !best_q[gsha_pkg::SCORE_W-1]) begin
					// new match: the held one is now known not to be last
					if (!pend_valid_q || slot_free) begin
						commit  = 1'b1;
						state_d = gsha_pkg::ST_ROUND;
						if (pend_valid_q) begin
							emit.valid = 1'b1;
							emit.found = 1'b1;
							emit.row   = pend_row_q;
							emit.col   = pend_col_q;
						end
					end
				end else begin
					state_d = gsha_pkg::ST_FINISH;
				end
			end
			gsha_pkg::ST_FINISH: begin
				if (slot_free) begin
					emit.valid = 1'b1;
					emit.found = pend_valid_q;
					emit.row   = pend_valid_q ? pend_row_q : '0;
					emit.col   = pend_valid_q ? pend_col_q : '0;
					emit.last  = 1'b1;
					state_d    = gsha_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = gsha_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= gsha_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rounds_q     <= '0;
			nr_q         <= '0;
			nc_q         <= '0;
			i_q          <= '0;
			j_q          <= '0;
			valid_s1     <= 1'b0;
			have_q       <= 1'b0;
			row_taken_q  <= '0;
			col_taken_q  <= '0;
			pend_valid_q <= 1'b0;
		end else begin
			valid_s1 <= issue;
			if (state_q == gsha_pkg::ST_IDLE && start) begin
				rounds_q <= (cfg.match_count > gsha_pkg::RESULT_CAP) ?
					gsha_pkg::RND_W'(gsha_pkg::RESULT_CAP) : gsha_pkg::RND_W'(cfg.match_count);
				nr_q <= (cfg.rows_used > gsha_pkg::MAX_ROWS) ?
					gsha_pkg::RN_W'(gsha_pkg::MAX_ROWS) : gsha_pkg::RN_W'(cfg.rows_used);
				nc_q <= (cfg.cols_used > gsha_pkg::MAX_COLS) ?
					gsha_pkg::CN_W'(gsha_pkg::MAX_COLS) : gsha_pkg::CN_W'(cfg.cols_used);
				row_taken_q  <= '0;
				col_taken_q  <= '0;
				pend_valid_q <= 1'b0;
			end
			if (round_init) begin
				i_q    <= '0;
				j_q    <= '0;
				have_q <= 1'b0;
			end
			if (issue) begin
				if (row_end) begin
					j_q <= '0;
					i_q <= i_q + 1'b1;
				end else begin
					j_q <= j_q + 1'b1;
				end
			end
			if (valid_s1 && elig_s1 && better) begin
				have_q <= 1'b1;
			end
			if (commit) begin
				row_taken_q[best_row_q] <= 1'b1;
				col_taken_q[best_col_q] <= 1'b1;
				pend_valid_q            <= 1'b1;
				rounds_q                <= rounds_q - 1'b1;
			end
		end
	end

	// payload side of the scan pipe
	always_ff @(posedge clk) begin
		row_s1  <= i_q;
		col_s1  <= j_q;
		elig_s1 <= !row_taken_q[i_q] && !col_taken_q[j_q];
		if (valid_s1 && elig_s1 && better) begin
			best_q     <= $signed(rd_data);
			best_row_q <= row_s1;
			best_col_q <= col_s1;
		end
		if (commit) begin
			pend_row_q <= best_row_q;
			pend_col_q <= best_col_q;
		end
	end

	assign rd_en   = issue;
	assign rd_addr = gsha_pkg::cell_addr(i_q, j_q);

	assign status.busy       = (state_q != gsha_pkg::ST_IDLE);
	assign status.pend_valid = pend_valid_q;

endmodule

// ===== hw/rtl/greedy_soft_to_hard_assignment_top.sv =====
`timescale 1ns / 1ps
// greedy_soft_to_hard_assignment_top: config registers, score RAM, scan engine
// and the result register. Depends on gsha_pkg, gsha_ram, gsha_scan.
//
// channel | handshake            | payload
// --------+----------------------+-------------------------------
// in      | in_valid / in_ready  | kind, row, col, score
// out     | out_valid / out_ready| found, match_row, match_col, last
// cfg     | cfg_we               | cfg_index, cfg_data
//
// Loads stream back to back into the RAM. A run request holds in_ready low
// until its final result is handed to the result register. Each round reads
// every cell of the active rows_used x cols_used window through the single
// RAM read port. Reset clears control state and sets match_count=1,
// rows_used=cols_used=16; the score RAM is not cleared. A stalled result
// only delays the next emit.
module greedy_soft_to_hard_assignment_top (
	input  logic                            clk,
	input  logic                            arst_n,
	// request channel
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic                            kind,
	input  logic [gsha_pkg::FIELD_W-1:0]    row,
	input  logic [gsha_pkg::FIELD_W-1:0]    col,
	input  logic signed [gsha_pkg::SCORE_W-1:0] score,
	// result channel
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic                            found,
	output logic [gsha_pkg::FIELD_W-1:0]    match_row,
	output logic [gsha_pkg::FIELD_W-1:0]    match_col,
	output logic                            last,
	// configuration
	input  logic                            cfg_we,
	input  logic [gsha_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [gsha_pkg::CFG_W-1:0]      cfg_data
);

	gsha_pkg::cfg_t    cfg_q;
	gsha_pkg::emit_t   emit;
	gsha_pkg::status_t status;

	logic                          in_acc;
	logic                          start;
	logic                          load_we;
	logic                          slot_free;
	logic                          rd_en;
	logic [gsha_pkg::ADDR_W-1:0]   rd_addr;
	logic [gsha_pkg::SCORE_W-1:0]  rd_data;

	logic                          out_valid_q;
	logic                          found_q;
	logic                          last_q;
	logic [gsha_pkg::ROW_W-1:0]    row_q;
	logic [gsha_pkg::COL_W-1:0]    col_q;

	// config writes must land only while idle; the block itself does not enforce it, the scan copies them at start
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.match_count <= gsha_pkg::CFG_W'(1);
			cfg_q.rows_used   <= gsha_pkg::CFG_W'(16);
			cfg_q.cols_used   <= gsha_pkg::CFG_W'(16);
		end else if (cfg_we) begin
			case (cfg_index)
				gsha_pkg::CFG_MATCH_COUNT: cfg_q.match_count <= cfg_data;
				gsha_pkg::CFG_ROWS_USED:   cfg_q.rows_used   <= cfg_data;
				gsha_pkg::CFG_COLS_USED:   cfg_q.cols_used   <= cfg_data;
				default: ;
			endcase
		end
	end

	// requests are taken whenever no run is in flight
	assign in_ready = !status.busy;
	assign in_acc   = in_valid && in_ready;
	assign start    = in_acc && (kind == gsha_pkg::KIND_RUN);
	// loads outside the matrix are dropped
	assign load_we  = in_acc && (kind == gsha_pkg::KIND_LOAD) &&
		(row < gsha_pkg::MAX_ROWS) && (col < gsha_pkg::MAX_COLS);

	gsha_ram #(
		.WIDTH (gsha_pkg::SCORE_W),
		.DEPTH (gsha_pkg::DEPTH)
	) u_score_ram (
		.clk   (clk),
		.we    (load_we),
		.waddr (gsha_pkg::cell_addr(gsha_pkg::ROW_W'(row), gsha_pkg::COL_W'(col))),
		.wdata (score),
		.re    (rd_en),
		.raddr (rd_addr),
		.rdata (rd_data)
	);

	gsha_scan u_scan (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.cfg       (cfg_q),
		.slot_free (slot_free),
		.rd_en     (rd_en),
		.rd_addr   (rd_addr),
		.rd_data   (rd_data),
		.emit      (emit),
		.status    (status)
	);

	// single result register; it frees up the same cycle it is taken
	assign slot_free = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit.valid) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit.valid) begin
			found_q <= emit.found;
			last_q  <= emit.last;
			row_q   <= emit.row;
			col_q   <= emit.col;
		end
	end

	assign out_valid = out_valid_q;
	assign found     = found_q;
	assign last      = last_q;
	assign match_row = gsha_pkg::FIELD_W'(row_q);
	assign match_col = gsha_pkg::FIELD_W'(col_q);

`ifndef ASSERT_OFF
	// the scan engine never overwrites a result that was not taken
	a_emit_slot: assert property (@(posedge clk) disable iff (!arst_n)
		emit.valid |-> slot_free)
		else $error("result emitted while result register is full");

	// an accepted run keeps the request side closed on the next cycle
	a_run_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start |=> (status.busy && !in_ready))
		else $error("run did not occupy the scan engine");

	// an empty result is always the closing one and carries zero indexes
	a_empty_last: assert property (@(posedge clk) disable iff (!arst_n)
		(emit.valid && !emit.found) |-> (emit.last && emit.row == '0 && emit.col == '0))
		else $error("empty result malformed");

	// the scan engine goes idle once the final result is emitted
	a_pend_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(emit.valid && emit.last) |=> !status.busy)
		else $error("scan engine busy after final result");
`endif

endmodule
